>>> rtl/core/mcbp_pkg.sv
// ----------------------------------------------------------------------------
// mcbp_pkg
// Shared types for the byte pipe pool: operation codes, status codes and
// the response record that travels from the control logic to the output side.
// ----------------------------------------------------------------------------
package mcbp_pkg;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLOSE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_NO_FREE     = 3'd1,
        STATUS_WOULD_BLOCK = 3'd2,
        STATUS_BROKEN_PIPE = 3'd3,
        STATUS_END_OF_DATA = 3'd4
    } status_t;

    typedef struct packed {
        logic        is_read;
        status_t     status;
        logic [2:0]  pipe_id;
    } resp_t;

endpackage

>>> rtl/core/multi_channel_byte_pipe_pool_core.sv
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe_pool_core
// Pool of byte pipes that allocates, writes, reads and closes one pipe per
// transfer, with a shared byte store and an output register.
// ----------------------------------------------------------------------------
// The core takes one transfer per clock cycle unless in_stall is high, and
// registers its result in a holding stage and then in the output register;
// the single-port byte store, serving one write or one read per cycle, sets
// that rate. While the output stalls, one further transfer is taken and held.
module multi_channel_byte_pipe_pool_core #(
    parameter int NUM_PIPES  = 8,
    parameter int PIPE_BYTES = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mcbp_pkg::func_t     func,
    input  logic [2:0]          pipe_id,
    input  logic [7:0]          data_in,
    input  logic                close_write_end,
    output logic                out_valid,
    input  logic                out_stall,
    output mcbp_pkg::status_t   status,
    output logic [7:0]          data_out,
    output logic [2:0]          pipe_id_out
);

    import mcbp_pkg::*;

    localparam int DEPTH  = NUM_PIPES * PIPE_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              issue;
    logic              b_move;
    resp_t             resp;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    logic              b_valid_reg;
    logic              b_valid_next;
    resp_t             b_resp_reg;
    resp_t             b_resp_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [7:0]        data_out_reg;
    logic [7:0]        data_out_next;
    logic [2:0]        pipe_id_out_reg;
    logic [2:0]        pipe_id_out_next;

    assign b_move   = b_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = b_valid_reg && out_valid_reg && out_stall;
    assign issue    = in_valid && !in_stall;

    mcbp_ctrl #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_BYTES (PIPE_BYTES),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .issue           (issue),
        .func            (func),
        .pipe_id         (pipe_id),
        .data_in         (data_in),
        .close_write_end (close_write_end),
        .resp            (resp),
        .mem_we          (mem_we),
        .mem_re          (mem_re),
        .mem_addr        (mem_addr),
        .mem_wdata       (mem_wdata)
    );

    mcbp_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        b_valid_next     = b_valid_reg;
        b_resp_next      = b_resp_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        data_out_next    = data_out_reg;
        pipe_id_out_next = pipe_id_out_reg;
        if (b_move)
        begin
            b_valid_next     = 1'b0;
            out_valid_next   = 1'b1;
            status_next      = b_resp_reg.status;
            data_out_next    = b_resp_reg.is_read ? mem_rdata : 8'd0;
            pipe_id_out_next = b_resp_reg.pipe_id;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (issue)
        begin
            b_valid_next = 1'b1;
            b_resp_next  = resp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_resp_reg      <= b_resp_next;
        status_reg      <= status_next;
        data_out_reg    <= data_out_next;
        pipe_id_out_reg <= pipe_id_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_out    = data_out_reg;
    assign pipe_id_out = pipe_id_out_reg;

endmodule

>>> rtl/core/mcbp_store.sv
// ----------------------------------------------------------------------------
// mcbp_store
// Single-port synchronous byte memory holding the ring buffers of all pipes,
// with registered read data.
// ----------------------------------------------------------------------------
module mcbp_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mcbp_ctrl.sv
// ----------------------------------------------------------------------------
// mcbp_ctrl
// Per-pipe counters and end flags, operation decode, free-pipe search and
// byte store address generation for one transfer per cycle.
// ----------------------------------------------------------------------------
module mcbp_ctrl #(
    parameter int NUM_PIPES  = 8,
    parameter int PIPE_BYTES = 512,
    parameter int ADDR_W     = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  mcbp_pkg::func_t     func,
    input  logic [2:0]          pipe_id,
    input  logic [7:0]          data_in,
    input  logic                close_write_end,
    output mcbp_pkg::resp_t     resp,
    output logic                mem_we,
    output logic                mem_re,
    output logic [ADDR_W-1:0]   mem_addr,
    output logic [7:0]          mem_wdata
);

    import mcbp_pkg::*;

    localparam int IDX_W  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int SEL_W  = (IDX_W > 3) ? IDX_W : 3;
    localparam int CNT_W  = $clog2(2 * PIPE_BYTES);
    localparam int SLOT_W = $clog2(PIPE_BYTES);

    logic [CNT_W-1:0] read_count_reg  [NUM_PIPES];
    logic [CNT_W-1:0] read_count_next [NUM_PIPES];
    logic [CNT_W-1:0] write_count_reg  [NUM_PIPES];
    logic [CNT_W-1:0] write_count_next [NUM_PIPES];
    logic [NUM_PIPES-1:0] reader_open_reg;
    logic [NUM_PIPES-1:0] reader_open_next;
    logic [NUM_PIPES-1:0] writer_open_reg;
    logic [NUM_PIPES-1:0] writer_open_next;

    logic [SEL_W-1:0]  pid_ext;
    logic [IDX_W-1:0]  idx;
    logic              pid_ok;
    logic [CNT_W-1:0]  rc;
    logic [CNT_W-1:0]  wc;
    logic [CNT_W:0]    diff;
    logic [CNT_W:0]    fill;
    logic              is_full;
    logic              is_empty;
    logic [CNT_W-1:0]  cnt_sel;
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic [IDX_W-1:0]  free_idx;
    logic [SEL_W-1:0]  free_ext;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == CNT_W'(2 * PIPE_BYTES - 1))
        begin
            r = '0;
        end
        else
        begin
            r = c + CNT_W'(1);
        end
        return r;
    endfunction

    assign pid_ext = SEL_W'(pipe_id);
    assign idx     = pid_ext[IDX_W-1:0];
    assign pid_ok  = (32'(pipe_id) < NUM_PIPES);
    assign rc      = read_count_reg[idx];
    assign wc      = write_count_reg[idx];

    always_comb
    begin
        diff = {1'b0, wc} - {1'b0, rc};
        if (wc >= rc)
        begin
            fill = diff;
        end
        else
        begin
            fill = diff + (CNT_W + 1)'(2 * PIPE_BYTES);
        end
        is_full  = (fill >= (CNT_W + 1)'(PIPE_BYTES));
        is_empty = (wc == rc);
    end

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            if (!reader_open_reg[i] && !writer_open_reg[i])
            begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign free_ext = SEL_W'(free_idx);

    always_comb
    begin
        cnt_sel = (func == FUNC_WRITE) ? wc : rc;
        if (cnt_sel >= CNT_W'(PIPE_BYTES))
        begin
            slot = SLOT_W'(cnt_sel - CNT_W'(PIPE_BYTES));
        end
        else
        begin
            slot = SLOT_W'(cnt_sel);
        end
        mem_addr = ADDR_W'(idx) * ADDR_W'(PIPE_BYTES) + ADDR_W'(slot);
    end

    assign mem_wdata = data_in;

    always_comb
    begin
        read_count_next  = read_count_reg;
        write_count_next = write_count_reg;
        reader_open_next = reader_open_reg;
        writer_open_next = writer_open_reg;
        resp.is_read     = 1'b0;
        resp.status      = STATUS_OK;
        resp.pipe_id     = pipe_id;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        unique case (func)
            FUNC_ALLOC:
            begin
                if (found)
                begin
                    read_count_next[free_idx]  = '0;
                    write_count_next[free_idx] = '0;
                    reader_open_next[free_idx] = 1'b1;
                    writer_open_next[free_idx] = 1'b1;
                    resp.pipe_id               = free_ext[2:0];
                end
                else
                begin
                    resp.status  = STATUS_NO_FREE;
                    resp.pipe_id = 3'd0;
                end
            end
            FUNC_WRITE:
            begin
                if (!pid_ok || !reader_open_reg[idx])
                begin
                    resp.status = STATUS_BROKEN_PIPE;
                end
                else if (is_full)
                begin
                    resp.status = STATUS_WOULD_BLOCK;
                end
                else
                begin
                    mem_we                = issue;
                    write_count_next[idx] = cnt_inc(wc);
                end
            end
            FUNC_READ:
            begin
                if (!pid_ok)
                begin
                    resp.status = STATUS_END_OF_DATA;
                end
                else if (is_empty)
                begin
                    resp.status = writer_open_reg[idx] ? STATUS_WOULD_BLOCK
                                                       : STATUS_END_OF_DATA;
                end
                else
                begin
                    mem_re               = issue;
                    resp.is_read         = 1'b1;
                    read_count_next[idx] = cnt_inc(rc);
                end
            end
            FUNC_CLOSE:
            begin
                if (pid_ok)
                begin
                    if (close_write_end)
                    begin
                        writer_open_next[idx] = 1'b0;
                    end
                    else
                    begin
                        reader_open_next[idx] = 1'b0;
                    end
                end
            end
            default:
            begin
                resp.status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                read_count_reg[i]  <= '0;
                write_count_reg[i] <= '0;
            end
            reader_open_reg <= '0;
            writer_open_reg <= '0;
        end
        else if (issue)
        begin
            read_count_reg  <= read_count_next;
            write_count_reg <= write_count_next;
            reader_open_reg <= reader_open_next;
            writer_open_reg <= writer_open_next;
        end
    end

endmodule

>>> test/multi_channel_byte_pipe_pool_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe_pool_core_test
// Self-checking bench for the byte pipe pool. A queue of operations is
// prepared up front: a directed opening, one long stream that keeps a pipe
// full across both pointer wraps, then short sessions of mixed traffic on
// freshly allocated pipes. Each accepted transfer is run through a local
// model of the pool, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module multi_channel_byte_pipe_pool_core_test;

    import mcbp_pkg::*;

    localparam int NUM_PIPES    = 8;
    localparam int PIPE_BYTES   = 512;
    localparam int PTR_W        = $clog2(2 * PIPE_BYTES);
    localparam int SLOT_W       = $clog2(PIPE_BYTES);
    localparam int RANDOM_ITEMS = 1850;

    typedef struct packed {
        func_t      func;
        logic [2:0] pipe;
        logic [7:0] data;
        logic       close_wr;
    } pipe_op_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic [2:0] pipe;
    } pipe_reply_t;

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    func_t       func = FUNC_ALLOC;
    logic [2:0]  pipe_id = 3'd0;
    logic [7:0]  data_in = 8'h00;
    logic        close_write_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    status_t     status;
    logic [7:0]  data_out;
    logic [2:0]  pipe_id_out;

    logic [7:0]       pool_bytes [NUM_PIPES * PIPE_BYTES];
    logic [PTR_W-1:0] rd_ptr [NUM_PIPES];
    logic [PTR_W-1:0] wr_ptr [NUM_PIPES];
    logic             rd_open [NUM_PIPES];
    logic             wr_open [NUM_PIPES];

    pipe_op_t    pending_ops [$];
    pipe_reply_t awaited_replies [$];
    pipe_op_t    next_op;

    int queued_ops = 0;
    int accepted_ops = 0;
    int random_ops = 0;
    int checked_replies = 0;
    int errors = 0;
    int status_hits [5] = '{default: 0};

    int       burst_left;
    int       gap_left;
    rx_mode_t rx_mode;
    int       mode_left;

    multi_channel_byte_pipe_pool_core #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_BYTES (PIPE_BYTES)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .pipe_id         (pipe_id),
        .data_in         (data_in),
        .close_write_end (close_write_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .data_out        (data_out),
        .pipe_id_out     (pipe_id_out)
    );

    always #5 clk = ~clk;

    function automatic pipe_reply_t pool_apply(pipe_op_t op);
        pipe_reply_t      reply;
        int               p;
        logic [PTR_W-1:0] level;
        p = op.pipe;
        reply.status = STATUS_OK;
        reply.data = 8'h00;
        reply.pipe = op.pipe;
        level = '0;
        if (p < NUM_PIPES)
        begin
            level = wr_ptr[p] - rd_ptr[p];
        end
        case (op.func)
            FUNC_ALLOC:
            begin
                p = NUM_PIPES;
                for (int i = NUM_PIPES - 1; i >= 0; i--)
                begin
                    if (!rd_open[i] && !wr_open[i])
                    begin
                        p = i;
                    end
                end
                if (p < NUM_PIPES)
                begin
                    rd_ptr[p] = '0;
                    wr_ptr[p] = '0;
                    rd_open[p] = 1'b1;
                    wr_open[p] = 1'b1;
                    reply.pipe = p[2:0];
                end
                else
                begin
                    reply.status = STATUS_NO_FREE;
                    reply.pipe = 3'd0;
                end
            end
            FUNC_WRITE:
            begin
                if (p >= NUM_PIPES || !rd_open[p])
                begin
                    reply.status = STATUS_BROKEN_PIPE;
                end
                else if (level >= PIPE_BYTES)
                begin
                    reply.status = STATUS_WOULD_BLOCK;
                end
                else
                begin
                    pool_bytes[p * PIPE_BYTES + int'(wr_ptr[p][SLOT_W-1:0])] = op.data;
                    wr_ptr[p] = wr_ptr[p] + 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (p >= NUM_PIPES)
                begin
                    reply.status = STATUS_END_OF_DATA;
                end
                else if (level == 0)
                begin
                    reply.status = wr_open[p] ? STATUS_WOULD_BLOCK : STATUS_END_OF_DATA;
                end
                else
                begin
                    reply.data = pool_bytes[p * PIPE_BYTES + int'(rd_ptr[p][SLOT_W-1:0])];
                    rd_ptr[p] = rd_ptr[p] + 1'b1;
                end
            end
            default:
            begin
                if (p < NUM_PIPES)
                begin
                    if (op.close_wr)
                    begin
                        wr_open[p] = 1'b0;
                    end
                    else
                    begin
                        rd_open[p] = 1'b0;
                    end
                end
            end
        endcase
        return reply;
    endfunction

    task automatic queue_op(func_t f, int pipe, bit counted);
        pipe_op_t op;
        op.func = f;
        op.pipe = pipe[2:0];
        op.data = 8'($urandom_range(255, 0));
        op.close_wr = 1'($urandom_range(1, 0));
        pending_ops.push_back(op);
        queued_ops++;
        if (counted)
        begin
            random_ops++;
        end
    endtask

    task automatic queue_close(int pipe, bit writer_end, bit counted);
        pipe_op_t op;
        op.func = FUNC_CLOSE;
        op.pipe = pipe[2:0];
        op.data = 8'($urandom_range(255, 0));
        op.close_wr = writer_end;
        pending_ops.push_back(op);
        queued_ops++;
        if (counted)
        begin
            random_ops++;
        end
    endtask

    task automatic free_all_pipes();
        for (int q = 0; q < NUM_PIPES; q++)
        begin
            queue_close(q, 1'b0, 1'b0);
            queue_close(q, 1'b1, 1'b0);
        end
    endtask

    task automatic note_mismatch(string what, int want, int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_ALLOC;
            pipe_id <= 3'd0;
            data_in <= 8'h00;
            close_write_end <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                rd_ptr[i] = '0;
                wr_ptr[i] = '0;
                rd_open[i] = 1'b0;
                wr_open[i] = 1'b0;
            end
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                awaited_replies.push_back(
                    pool_apply(pipe_op_t'{func, pipe_id, data_in, close_write_end}));
                accepted_ops++;
            end
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ops.size() != 0)
            begin
                next_op = pending_ops.pop_front();
                in_valid <= 1'b1;
                func <= next_op.func;
                pipe_id <= next_op.pipe;
                data_in <= next_op.data;
                close_write_end <= next_op.close_wr;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(24, 1);
                    gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(5, 1);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result and stalls in modes that change over time.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_mode <= RX_FLOW;
            mode_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, status, data_out, pipe_id_out);
                end
                else
                begin
                    checked_replies++;
                    status_hits[int'(awaited_replies[0].status)]++;
                    if (status !== awaited_replies[0].status)
                    begin
                        note_mismatch("status", awaited_replies[0].status, status);
                    end
                    if (data_out !== awaited_replies[0].data)
                    begin
                        note_mismatch("data_out", awaited_replies[0].data, data_out);
                    end
                    if (pipe_id_out !== awaited_replies[0].pipe)
                    begin
                        note_mismatch("pipe_id_out", awaited_replies[0].pipe, pipe_id_out);
                    end
                    void'(awaited_replies.pop_front());
                end
            end
            if (mode_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(3, 0));
                mode_left <= $urandom_range(80, 10);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FLOW:     out_stall <= 1'b0;
                RX_LIGHT:    out_stall <= ($urandom_range(3, 0) == 0);
                RX_HEAVY:    out_stall <= ($urandom_range(3, 0) != 0);
                default:     out_stall <= ((mode_left % 3) == 0);
            endcase
        end
    end

    initial
    begin
        int    extra;
        int    live;
        int    span;
        int    pick;
        int    target;
        func_t kind;

        // Directed opening on a pool that has just come out of reset.
        queue_op(FUNC_READ, 0, 1'b0);
        queue_op(FUNC_WRITE, 7, 1'b0);
        queue_op(FUNC_ALLOC, 5, 1'b0);
        queue_op(FUNC_WRITE, 0, 1'b0);
        queue_op(FUNC_WRITE, 0, 1'b0);
        queue_op(FUNC_READ, 0, 1'b0);
        queue_op(FUNC_READ, 0, 1'b0);
        queue_op(FUNC_READ, 0, 1'b0);
        queue_op(FUNC_WRITE, 0, 1'b0);
        queue_close(0, 1'b1, 1'b0);
        queue_op(FUNC_WRITE, 0, 1'b0);
        queue_op(FUNC_READ, 0, 1'b0);
        queue_op(FUNC_READ, 0, 1'b0);
        queue_op(FUNC_READ, 0, 1'b0);
        queue_close(0, 1'b0, 1'b0);
        repeat (NUM_PIPES + 1)
        begin
            queue_op(FUNC_ALLOC, $urandom_range(7, 0), 1'b0);
        end

        // Keep pipe 0 full while both pointers travel past their wrap points.
        free_all_pipes();
        extra = $urandom_range(3, 1);
        repeat (extra + 1)
        begin
            queue_op(FUNC_ALLOC, $urandom_range(7, 0), 1'b1);
        end
        repeat (PIPE_BYTES + 1)
        begin
            queue_op(FUNC_WRITE, 0, 1'b1);
        end
        repeat (PIPE_BYTES)
        begin
            queue_op(FUNC_READ, 0, 1'b1);
            queue_op(FUNC_WRITE, 0, 1'b1);
            if ($urandom_range(15, 0) == 0)
            begin
                queue_op(FUNC_WRITE, 0, 1'b1);
            end
            if ($urandom_range(7, 0) == 0)
            begin
                queue_op(($urandom_range(1, 0) != 0) ? FUNC_WRITE : FUNC_READ,
                         $urandom_range(extra, 1), 1'b1);
            end
        end
        queue_close(0, 1'b0, 1'b1);
        queue_op(FUNC_WRITE, 0, 1'b1);
        queue_op(FUNC_READ, 0, 1'b1);
        queue_close(0, 1'b1, 1'b1);

        // Short sessions of mixed traffic on a freshly allocated set of pipes.
        while (random_ops < RANDOM_ITEMS)
        begin
            free_all_pipes();
            live = $urandom_range(NUM_PIPES + 1, 1);
            repeat (live)
            begin
                queue_op(FUNC_ALLOC, $urandom_range(7, 0), 1'b1);
            end
            if (live > NUM_PIPES)
            begin
                live = NUM_PIPES;
            end
            span = $urandom_range(120, 30);
            repeat (span)
            begin
                pick = $urandom_range(99, 0);
                if ($urandom_range(3, 0) == 0)
                begin
                    target = $urandom_range(NUM_PIPES - 1, 0);
                end
                else
                begin
                    target = $urandom_range(live - 1, 0);
                end
                if (pick < 45)
                begin
                    kind = FUNC_WRITE;
                end
                else if (pick < 85)
                begin
                    kind = FUNC_READ;
                end
                else if (pick < 93)
                begin
                    kind = FUNC_CLOSE;
                end
                else
                begin
                    kind = FUNC_ALLOC;
                end
                queue_op(kind, target, 1'b1);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_ops != queued_ops) @(posedge clk);
        while (awaited_replies.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Run covered %0d transfers and %0d checked results: ok %0d, no free pipe %0d,",
                 accepted_ops, checked_replies, status_hits[0], status_hits[1]);
        $display("would block %0d, broken pipe %0d, end of data %0d.",
                 status_hits[2], status_hits[3], status_hits[4]);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d of %0d transfers accepted, %0d results outstanding",
                 accepted_ops, queued_ops, awaited_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mcbp_pkg.sv
rtl/core/mcbp_store.sv
rtl/core/mcbp_ctrl.sv
rtl/core/multi_channel_byte_pipe_pool_core.sv
test/multi_channel_byte_pipe_pool_core_test.sv
